FILE: sv/abbrev_table_leb128_parser_top_macros.svh
// Assertion macros for the abbreviation table parser.
`ifndef ABBREV_TABLE_LEB128_PARSER_TOP_MACROS_SVH
`define ABBREV_TABLE_LEB128_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABTLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ABTLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/abtlp_pkg.sv
// Shared types and constants of the abbreviation table parser.
package abtlp_pkg;

    localparam logic [1:0] KIND_ENTRY_HEADER = 2'd0;
    localparam logic [1:0] KIND_ATTR_SPEC    = 2'd1;
    localparam logic [1:0] KIND_ENTRY_END    = 2'd2;
    localparam logic [1:0] KIND_TABLE_END    = 2'd3;

    localparam logic [63:0] FORM_IMPLICIT_CONST = 64'h21;
    localparam logic [6:0]  LEB_PAYLOAD_MASK    = 7'h7f;
    localparam logic [6:0]  LEB_STEP            = 7'd7;
    localparam logic [6:0]  LEB_SHIFT_LIMIT     = 7'd64;
    localparam logic [6:0]  LEB_SHIFT_SAT       = 7'd70;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        entry_code;
        logic [15:0]        entry_tag;
        logic               has_children;
        logic [15:0]        attr_name;
        logic [15:0]        attr_form;
        logic signed [63:0] implicit_value;
        logic               code_match;
        logic               oversize;
    } t_result;

endpackage

FILE: sv/abtlp_if.sv
// Handshake channel interfaces: table bytes, parse results, configuration write.
interface abtlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       table_start;

    modport source (output valid, output byte_in, output table_start, input ready);
    modport sink   (input valid, input byte_in, input table_start, output ready);
endinterface

interface abtlp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        entry_code;
    logic [15:0]        entry_tag;
    logic               has_children;
    logic [15:0]        attr_name;
    logic [15:0]        attr_form;
    logic signed [63:0] implicit_value;
    logic               code_match;
    logic               oversize;

    modport source (output valid, output kind, output entry_code, output entry_tag,
                    output has_children, output attr_name, output attr_form,
                    output implicit_value, output code_match, output oversize,
                    input ready);
    modport sink   (input valid, input kind, input entry_code, input entry_tag,
                    input has_children, input attr_name, input attr_form,
                    input implicit_value, input code_match, input oversize,
                    output ready);
endinterface

interface abtlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] search_code;

    modport source (output valid, output search_code, input ready);
    modport sink   (input valid, input search_code, output ready);
endinterface

FILE: sv/abtlp_parse.sv
// Input register and byte-serial parse state with its next-state logic.
module abtlp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    abtlp_in_if.sink           i_byte_if,
    input  logic [31:0]        i_search_code,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output abtlp_pkg::t_result o_res
);
    import abtlp_pkg::*;

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_CHILD = 3'd2,
        PH_NAME  = 3'd3,
        PH_FORM  = 3'd4,
        PH_CONST = 3'd5
    } t_phase;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;

    t_phase      r_phase,  n_phase;
    logic [63:0] r_acc,    n_acc;
    logic [6:0]  r_sc,     n_sc;
    logic [31:0] r_code,   n_code;
    logic [15:0] r_tag,    n_tag;
    logic [15:0] r_name,   n_name;
    logic [15:0] r_form,   n_form;
    logic        r_ovp,    n_ovp;

    logic        advance;
    logic        emit;
    t_result     res;
    t_phase      ph;
    logic [63:0] acc, acc_new, v_const;
    logic [6:0]  sc, sc_new;
    logic        ovp, last;

    assign advance         = r_in_valid && i_res_ready;
    assign i_byte_if.ready = !r_in_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_if.ready) begin
            r_in_valid <= i_byte_if.valid;
        end
        if (i_byte_if.ready && i_byte_if.valid) begin
            r_byte  <= i_byte_if.byte_in;
            r_start <= i_byte_if.table_start;
        end
    end

    // Restart takes effect before the byte is used.
    always_comb begin
        ph      = r_start ? PH_CODE : r_phase;
        acc     = r_start ? 64'd0 : r_acc;
        sc      = r_start ? 7'd0 : r_sc;
        ovp     = r_start ? 1'b0 : r_ovp;
        last    = !r_byte[7];
        acc_new = (sc < LEB_SHIFT_LIMIT)
                ? (acc | ({57'd0, r_byte[6:0] & LEB_PAYLOAD_MASK} << sc[5:0])) : acc;
        sc_new  = (sc >= (LEB_SHIFT_LIMIT - 7'd1)) ? LEB_SHIFT_SAT : sc + LEB_STEP;
        v_const = acc_new;
        if (sc_new < LEB_SHIFT_LIMIT && r_byte[6]) begin
            v_const = acc_new | ({64{1'b1}} << sc_new[5:0]);
        end
    end

    always_comb begin
        n_phase = ph;
        n_acc   = acc;
        n_sc    = sc;
        n_code  = r_code;
        n_tag   = r_tag;
        n_name  = r_name;
        n_form  = r_form;
        n_ovp   = ovp;
        emit    = 1'b0;
        res     = '0;
        res.entry_code = r_code;

        unique case (ph)
            PH_CODE: begin
                n_acc = acc_new;
                n_sc  = sc_new;
                if (last) begin
                    n_acc = 64'd0;
                    n_sc  = 7'd0;
                    if (acc_new == 64'd0) begin
                        n_code         = 32'd0;
                        n_ovp          = 1'b0;
                        emit           = 1'b1;
                        res.kind       = KIND_TABLE_END;
                        res.entry_code = 32'd0;
                    end else begin
                        n_code  = acc_new[31:0];
                        n_ovp   = |acc_new[63:32];
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                n_acc = acc_new;
                n_sc  = sc_new;
                if (last) begin
                    n_acc   = 64'd0;
                    n_sc    = 7'd0;
                    n_tag   = acc_new[15:0];
                    n_ovp   = ovp | (|acc_new[63:16]);
                    n_phase = PH_CHILD;
                end
            end
            PH_CHILD: begin
                n_ovp            = 1'b0;
                n_phase          = PH_NAME;
                emit             = 1'b1;
                res.kind         = KIND_ENTRY_HEADER;
                res.entry_tag    = r_tag;
                res.has_children = |r_byte;
                res.oversize     = ovp;
            end
            PH_NAME: begin
                n_acc = acc_new;
                n_sc  = sc_new;
                if (last) begin
                    n_acc   = 64'd0;
                    n_sc    = 7'd0;
                    n_name  = acc_new[15:0];
                    n_ovp   = |acc_new[63:16];
                    n_phase = PH_FORM;
                end
            end
            PH_FORM: begin
                n_acc = acc_new;
                n_sc  = sc_new;
                if (last) begin
                    n_acc = 64'd0;
                    n_sc  = 7'd0;
                    // Terminator needs both full values zero.
                    if (acc_new == 64'd0 && r_name == 16'd0 && !ovp) begin
                        n_phase  = PH_CODE;
                        emit     = 1'b1;
                        res.kind = KIND_ENTRY_END;
                    end else begin
                        n_form = acc_new[15:0];
                        n_ovp  = ovp | (|acc_new[63:16]);
                        if (acc_new == FORM_IMPLICIT_CONST) begin
                            n_phase = PH_CONST;
                        end else begin
                            n_ovp         = 1'b0;
                            n_phase       = PH_NAME;
                            emit          = 1'b1;
                            res.kind      = KIND_ATTR_SPEC;
                            res.attr_name = r_name;
                            res.attr_form = acc_new[15:0];
                            res.oversize  = ovp | (|acc_new[63:16]);
                        end
                    end
                end
            end
            PH_CONST: begin
                n_acc = acc_new;
                n_sc  = sc_new;
                if (last) begin
                    n_acc              = 64'd0;
                    n_sc               = 7'd0;
                    n_ovp              = 1'b0;
                    n_phase            = PH_NAME;
                    emit               = 1'b1;
                    res.kind           = KIND_ATTR_SPEC;
                    res.attr_name      = r_name;
                    res.attr_form      = r_form;
                    res.implicit_value = v_const;
                    res.oversize       = ovp;
                end
            end
            default: begin
                n_phase = PH_CODE;
                n_acc   = 64'd0;
                n_sc    = 7'd0;
            end
        endcase

        res.code_match = (res.kind != KIND_TABLE_END) && (i_search_code != 32'd0)
                       && (res.entry_code == i_search_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_acc   <= 64'd0;
            r_sc    <= 7'd0;
            r_code  <= 32'd0;
            r_tag   <= 16'd0;
            r_name  <= 16'd0;
            r_form  <= 16'd0;
            r_ovp   <= 1'b0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_sc    <= n_sc;
            r_code  <= n_code;
            r_tag   <= n_tag;
            r_name  <= n_name;
            r_form  <= n_form;
            r_ovp   <= n_ovp;
        end
    end

    assign o_res_valid = advance && emit;
    assign o_res       = res;

endmodule

FILE: sv/abtlp_out_reg.sv
// Result register that drives the result channel.
module abtlp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  abtlp_pkg::t_result i_res,
    output logic               o_ready,
    abtlp_out_if.source        o_result_if
);
    import abtlp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Load when empty or when the held result transfers this cycle.
    assign o_ready = !r_valid || o_result_if.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_result_if.valid          = r_valid;
    assign o_result_if.kind           = r_res.kind;
    assign o_result_if.entry_code     = r_res.entry_code;
    assign o_result_if.entry_tag      = r_res.entry_tag;
    assign o_result_if.has_children   = r_res.has_children;
    assign o_result_if.attr_name      = r_res.attr_name;
    assign o_result_if.attr_form      = r_res.attr_form;
    assign o_result_if.implicit_value = r_res.implicit_value;
    assign o_result_if.code_match     = r_res.code_match;
    assign o_result_if.oversize       = r_res.oversize;

endmodule

FILE: sv/abbrev_table_leb128_parser_top.sv
// Top level of the abbreviation table LEB128 parser.
// Takes one table byte per cycle, with no gaps, for as long as results are taken. A byte
// transfers into the input register, is parsed from there (LEB128 shift-accumulate and
// phase update in one combinational pass) and its result, if any, is then registered in
// the result register. A stalled result channel holds the input register, and the byte
// channel then takes no more than one byte.
// The search code register is written through its own channel, which is always ready.
module abbrev_table_leb128_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abtlp_in_if.sink    i_byte_if,
    abtlp_cfg_if.sink   i_cfg_if,
    abtlp_out_if.source o_result_if
);
    import abtlp_pkg::*;

    `include "abbrev_table_leb128_parser_top_macros.svh"

    logic [31:0] r_search_code;
    logic        res_valid;
    logic        res_ready;
    t_result     res;

    assign i_cfg_if.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_code <= 32'd0;
        end else if (i_cfg_if.valid) begin
            r_search_code <= i_cfg_if.search_code;
        end
    end

    abtlp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_if     (i_byte_if),
        .i_search_code (r_search_code),
        .i_res_ready   (res_ready),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    abtlp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (res_valid),
        .i_res       (res),
        .o_ready     (res_ready),
        .o_result_if (o_result_if)
    );

    `ABTLP_ASSERT_IMP(a_table_end_clean, i_clk, i_rst_n,
        o_result_if.valid && o_result_if.kind == KIND_TABLE_END,
        o_result_if.entry_code == 32'd0 && !o_result_if.code_match && !o_result_if.oversize)
    `ABTLP_ASSERT_IMP(a_entry_end_clean, i_clk, i_rst_n,
        o_result_if.valid && o_result_if.kind == KIND_ENTRY_END,
        o_result_if.attr_name == 16'd0 && o_result_if.attr_form == 16'd0
            && o_result_if.implicit_value == 64'sd0)
    `ABTLP_ASSERT_IMP(a_match_nonzero, i_clk, i_rst_n,
        res_valid && res.code_match,
        res.entry_code != 32'd0)
    `ABTLP_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n,
        o_result_if.valid && !o_result_if.ready,
        o_result_if.valid && $stable(o_result_if.kind) && $stable(o_result_if.entry_code)
            && $stable(o_result_if.attr_name) && $stable(o_result_if.attr_form)
            && $stable(o_result_if.implicit_value))

endmodule

FILE: test/abbrev_table_leb128_parser_top_tb.sv
// Self-checking testbench: directed and random table bytes against a parse predictor.
module abbrev_table_leb128_parser_top_tb;
    import abtlp_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 350;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_ROWS      = 25;

    typedef enum logic [2:0] {
        PH_CODE, PH_TAG, PH_CHILD, PH_NAME, PH_FORM, PH_CONST
    } parse_phase_e;

    typedef struct {
        logic [7:0] value;
        logic       start;
    } table_byte_t;

    typedef struct {
        logic [7:0] value;
        logic       start;
        logic       typed;
        t_result    res;
    } directed_row_t;

    localparam t_result NO_RESULT = '0;
    localparam t_result RES_TABLE_END =
        '{KIND_TABLE_END, 32'd0, 16'd0, 1'b0, 16'd0, 16'd0, 64'sd0, 1'b0, 1'b0};
    localparam t_result RES_HDR_ONE =
        '{KIND_ENTRY_HEADER, 32'd1, 16'h0011, 1'b1, 16'd0, 16'd0, 64'sd0, 1'b0, 1'b0};
    localparam t_result RES_ATTR_PLAIN =
        '{KIND_ATTR_SPEC, 32'd1, 16'd0, 1'b0, 16'h0003, 16'h0008, 64'sd0, 1'b0, 1'b0};
    localparam t_result RES_ATTR_NEG =
        '{KIND_ATTR_SPEC, 32'd1, 16'd0, 1'b0, 16'h0001, 16'h0021, -64'sd64, 1'b0, 1'b0};
    localparam t_result RES_ENTRY_END =
        '{KIND_ENTRY_END, 32'd1, 16'd0, 1'b0, 16'd0, 16'd0, 64'sd0, 1'b0, 1'b0};
    localparam t_result RES_HDR_WIDE =
        '{KIND_ENTRY_HEADER, 32'd0, 16'hffff, 1'b1, 16'd0, 16'd0, 64'sd0, 1'b0, 1'b1};
    localparam t_result RES_ATTR_WIDE =
        '{KIND_ATTR_SPEC, 32'd0, 16'd0, 1'b0, 16'd0, 16'd0, 64'sd0, 1'b0, 1'b1};

    // Code 2**32 truncates to 0; name 2**16 truncates to 0 and is no terminator.
    directed_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, RES_TABLE_END},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h11, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b1, RES_HDR_ONE},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'h08, 1'b0, 1'b1, RES_ATTR_PLAIN},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h21, 1'b0, 1'b0, NO_RESULT},
        '{8'h40, 1'b0, 1'b1, RES_ATTR_NEG},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1, RES_ENTRY_END},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT},
        '{8'hff, 1'b0, 1'b0, NO_RESULT},
        '{8'hff, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'hff, 1'b0, 1'b1, RES_HDR_WIDE},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h04, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1, RES_ATTR_WIDE},
        '{8'h00, 1'b1, 1'b1, RES_TABLE_END}
    };

    logic i_clk;
    logic i_rst_n;

    abtlp_in_if  byte_if ();
    abtlp_cfg_if cfg_if ();
    abtlp_out_if result_if ();

    abbrev_table_leb128_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_if   (byte_if),
        .i_cfg_if    (cfg_if),
        .o_result_if (result_if)
    );

    // Parser shadow state
    parse_phase_e prs_phase;
    logic [63:0]  prs_acc;
    int unsigned  prs_shift;
    logic [31:0]  prs_code;
    logic [15:0]  prs_tag;
    logic [15:0]  prs_name;
    logic [15:0]  prs_form;
    logic         prs_over;
    logic [31:0]  prs_search;

    t_result      expected_q [$];
    table_byte_t  byte_q [$];
    int           mismatch_cnt;
    bit           quiet;
    bit           start_next;
    bit           typed_now;
    t_result      typed_val;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_leb();
        prs_acc   = '0;
        prs_shift = 0;
    endfunction

    // Absorb one LEB128 byte; return 1 on the last byte of the value.
    function automatic bit take_leb_byte(input logic [7:0] b);
        if (prs_shift < 64)
            prs_acc = prs_acc | ({57'd0, b[6:0]} << prs_shift);
        prs_shift = (prs_shift + 7 > 70) ? 70 : prs_shift + 7;
        return !b[7];
    endfunction

    function automatic t_result make_result(input logic [1:0] kind, input logic [31:0] code,
                                            input logic [15:0] tag, input logic kids,
                                            input logic [15:0] name, input logic [15:0] form,
                                            input logic [63:0] imm, input logic over);
        t_result r;
        r.kind           = kind;
        r.entry_code     = code;
        r.entry_tag      = tag;
        r.has_children   = kids;
        r.attr_name      = name;
        r.attr_form      = form;
        r.implicit_value = imm;
        r.code_match     = (kind != KIND_TABLE_END) && (prs_search != 0) && (code == prs_search);
        r.oversize       = over;
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      output t_result r);
        logic [63:0] v;
        logic        over;
        r = '0;
        if (start) begin
            prs_phase = PH_CODE;
            clear_leb();
            prs_over = 1'b0;
        end
        case (prs_phase)
            PH_CODE: begin
                if (!take_leb_byte(b))
                    return 1'b0;
                v = prs_acc;
                clear_leb();
                if (v == 0) begin
                    prs_code = '0;
                    prs_over = 1'b0;
                    r = make_result(KIND_TABLE_END, '0, '0, 1'b0, '0, '0, '0, 1'b0);
                    return 1'b1;
                end
                prs_code  = v[31:0];
                prs_over  = (v > 64'hffff_ffff);
                prs_phase = PH_TAG;
                return 1'b0;
            end
            PH_TAG: begin
                if (!take_leb_byte(b))
                    return 1'b0;
                v = prs_acc;
                clear_leb();
                prs_tag = v[15:0];
                if (v > 64'hffff)
                    prs_over = 1'b1;
                prs_phase = PH_CHILD;
                return 1'b0;
            end
            PH_CHILD: begin
                over      = prs_over;
                prs_over  = 1'b0;
                prs_phase = PH_NAME;
                r = make_result(KIND_ENTRY_HEADER, prs_code, prs_tag, b != 0, '0, '0, '0, over);
                return 1'b1;
            end
            PH_NAME: begin
                if (!take_leb_byte(b))
                    return 1'b0;
                v = prs_acc;
                clear_leb();
                prs_name  = v[15:0];
                prs_over  = (v > 64'hffff);
                prs_phase = PH_FORM;
                return 1'b0;
            end
            PH_FORM: begin
                if (!take_leb_byte(b))
                    return 1'b0;
                v = prs_acc;
                clear_leb();
                // A truncated name that reads zero does not end the entry.
                if (v == 0 && prs_name == 0 && !prs_over) begin
                    prs_phase = PH_CODE;
                    r = make_result(KIND_ENTRY_END, prs_code, '0, 1'b0, '0, '0, '0, 1'b0);
                    return 1'b1;
                end
                prs_form = v[15:0];
                if (v > 64'hffff)
                    prs_over = 1'b1;
                if (v == FORM_IMPLICIT_CONST) begin
                    prs_phase = PH_CONST;
                    return 1'b0;
                end
                over      = prs_over;
                prs_over  = 1'b0;
                prs_phase = PH_NAME;
                r = make_result(KIND_ATTR_SPEC, prs_code, '0, 1'b0, prs_name, prs_form, '0, over);
                return 1'b1;
            end
            PH_CONST: begin
                if (!take_leb_byte(b))
                    return 1'b0;
                v = prs_acc;
                if (prs_shift < 64 && b[6])
                    v = v | ({64{1'b1}} << prs_shift);
                clear_leb();
                over      = prs_over;
                prs_over  = 1'b0;
                prs_phase = PH_NAME;
                r = make_result(KIND_ATTR_SPEC, prs_code, '0, 1'b0, prs_name, prs_form, v, over);
                return 1'b1;
            end
            default: begin
                prs_phase = PH_CODE;
                clear_leb();
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result predicted;
        bit      emitted;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            emitted = parse_byte(byte_if.byte_in, byte_if.table_start, predicted);
            if (typed_now)
                expected_q.push_back(typed_val);
            else if (emitted)
                expected_q.push_back(predicted);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t: unexpected result kind %0d code %h", $time,
                             result_if.kind, result_if.entry_code);
            end else begin
                want = expected_q.pop_front();
                check_field("kind", want.kind, result_if.kind);
                check_field("entry_code", want.entry_code, result_if.entry_code);
                check_field("entry_tag", want.entry_tag, result_if.entry_tag);
                check_field("has_children", want.has_children, result_if.has_children);
                check_field("attr_name", want.attr_name, result_if.attr_name);
                check_field("attr_form", want.attr_form, result_if.attr_form);
                check_field("implicit_value", want.implicit_value, result_if.implicit_value);
                check_field("code_match", want.code_match, result_if.code_match);
                check_field("oversize", want.oversize, result_if.oversize);
            end
        end
    end

    // Result side: random stall bursts, none once the run goes quiet.
    initial begin : result_stall
        int stall;
        stall = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                stall--;
            end else begin
                result_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall = $urandom_range(1, 6);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic start, input bit typed,
                             input t_result res);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.byte_in     <= value;
        byte_if.table_start <= start;
        typed_now = typed;
        typed_val = res;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    task automatic write_search(input logic [31:0] code);
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.search_code <= code;
        do @(posedge i_clk); while (!cfg_if.ready);
        prs_search = code;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Hold until every expected result has arrived or the wait limit runs out, then let the pipeline settle.
    task automatic drain();
        int waited;
        waited = 0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_byte(input logic [7:0] value);
        table_byte_t item;
        item.value = value;
        item.start = start_next;
        start_next = 1'b0;
        byte_q.push_back(item);
    endtask

    task automatic put_uleb(input logic [63:0] v, input int pad);
        logic [63:0] rest;
        logic [6:0]  low;
        rest = v;
        do begin
            low  = rest[6:0];
            rest = rest >> 7;
            put_byte({(rest != 0) || (pad > 0), low});
        end while (rest != 0);
        for (int i = 0; i < pad; i++)
            put_byte({i < pad - 1, 7'h00});
    endtask

    task automatic put_sleb(input logic signed [63:0] v, input int pad);
        logic signed [63:0] rest;
        logic [6:0]         low;
        bit                 done;
        rest = v;
        do begin
            low  = rest[6:0];
            rest = rest >>> 7;
            done = (rest == 0 && !low[6]) || (rest == -1 && low[6]);
            put_byte({!done || (pad > 0), low});
        end while (!done);
        // Pad with sign copies so the value stays the same.
        for (int i = 0; i < pad; i++)
            put_byte({i < pad - 1, low[6] ? 7'h7f : 7'h00});
    endtask

    // Random payload bytes; long ones push bits past 64 and saturate the shift.
    task automatic put_raw_leb(input int len);
        logic [7:0] value;
        for (int i = 0; i < len; i++) begin
            value    = 8'($urandom_range(0, 255));
            value[7] = (i < len - 1);
            put_byte(value);
        end
    endtask

    function automatic int pick_pad();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    function automatic logic [63:0] pick_value(input int unsigned bits);
        logic [63:0] top;
        logic [63:0] wide;
        top  = (64'd1 << bits) - 64'd1;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(1, 127));
            4, 5:       return wide & top;
            6:          return top;
            7:          return top + 64'd1;
            8:          return {64{1'b1}};
            default:    return wide;
        endcase
    endfunction

    function automatic logic [63:0] pick_code();
        logic [63:0] v;
        if (prs_search != 0 && $urandom_range(0, 2) == 0) begin
            // Sometimes match only through the truncated low 32 bits.
            if ($urandom_range(0, 3) == 0)
                v = {32'($urandom_range(1, 255)), prs_search};
            else
                v = {32'd0, prs_search};
        end else begin
            v = pick_value(32);
        end
        if (v == 0)
            v = 64'd1;
        return v;
    endfunction

    function automatic logic [63:0] pick_const();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7fff_ffff_ffff_ffff;
            2:       return {64{1'b1}};
            3:       return 64'd0;
            4, 5:    return {{56{b[7]}}, b};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic gen_table();
        int          noise;
        int          n_entries;
        int          n_attrs;
        int          cut;
        logic [63:0] name;
        logic [63:0] form;
        if ($urandom_range(0, 9) == 0) begin
            noise = $urandom_range(1, 8);
            repeat (noise) begin
                start_next = ($urandom_range(0, 3) == 0);
                put_byte(8'($urandom_range(0, 255)));
            end
            start_next = 1'b1;
        end else if ($urandom_range(0, 1) == 0) begin
            start_next = 1'b1;
        end
        n_entries = $urandom_range(1, 4);
        repeat (n_entries) begin
            put_uleb(pick_code(), pick_pad());
            put_uleb(pick_value(16), pick_pad());
            case ($urandom_range(0, 2))
                0:       put_byte(8'h00);
                1:       put_byte(8'h01);
                default: put_byte(8'($urandom_range(0, 255)));
            endcase
            n_attrs = $urandom_range(0, 4);
            repeat (n_attrs) begin
                name = ($urandom_range(0, 15) == 0) ? 64'd0 : pick_value(16);
                form = ($urandom_range(0, 3) == 0) ? FORM_IMPLICIT_CONST : pick_value(16);
                if (name == 0 && form == 0)
                    form = 64'd1;
                put_uleb(name, pick_pad());
                put_uleb(form, pick_pad());
                if (form == FORM_IMPLICIT_CONST) begin
                    if ($urandom_range(0, 3) == 0)
                        put_raw_leb($urandom_range(1, 12));
                    else
                        put_sleb(pick_const(), pick_pad());
                end
            end
            put_uleb(64'd0, pick_pad());
            put_uleb(64'd0, pick_pad());
        end
        put_uleb(64'd0, pick_pad());
        // Break off the tail now and then; the next table restarts.
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, 5);
            repeat (cut)
                if (byte_q.size() > 0)
                    void'(byte_q.pop_back());
            start_next = 1'b1;
        end
    endtask

    initial begin : stimulus
        logic [31:0] search_plan [4];
        table_byte_t item;

        search_plan = '{32'hffff_ffff, 32'h0000_0001, $urandom, 32'h0000_0000};
        mismatch_cnt = 0;
        quiet        = 1'b0;
        start_next   = 1'b1;
        typed_now    = 1'b0;
        typed_val    = '0;
        prs_phase    = PH_CODE;
        prs_acc      = '0;
        prs_shift    = 0;
        prs_code     = '0;
        prs_tag      = '0;
        prs_name     = '0;
        prs_form     = '0;
        prs_over     = 1'b0;
        prs_search   = '0;

        i_rst_n             <= 1'b0;
        byte_if.valid       <= 1'b0;
        byte_if.byte_in     <= 8'h00;
        byte_if.table_start <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.search_code  <= 32'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_rows[i].value, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].res);

        for (int p = 0; p < 4; p++) begin
            @(negedge i_clk);
            byte_if.valid <= 1'b0;
            drain();
            write_search(search_plan[p]);
            quiet      = (p == 3);
            start_next = 1'b1;
            while (byte_q.size() < PHASE_ITEMS)
                gen_table();
            while (byte_q.size() > 0) begin
                item = byte_q.pop_front();
                send_byte(item.value, item.start, 1'b0, NO_RESULT);
            end
        end

        @(negedge i_clk);
        byte_if.valid <= 1'b0;
        drain();
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/abtlp_pkg.sv
sv/abtlp_if.sv
sv/abtlp_parse.sv
sv/abtlp_out_reg.sv
sv/abbrev_table_leb128_parser_top.sv
test/abbrev_table_leb128_parser_top_tb.sv
